[rtl/core/tttl_pkg.sv]
// tttl_pkg: shared types and constants of the three-track trigger looper
// loop store size, state structs, store write request and sequencer phases
// no dependencies
package tttl_pkg;

    localparam int LOOP_DEPTH = 65536;
    localparam int ADDR_W     = $clog2(LOOP_DEPTH);
    localparam int LEN_W      = ADDR_W + 1;
    localparam int TRK_N      = 3;
    localparam int SEL_W      = 2;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 8;

    localparam logic [LEN_W-1:0]  LOOP_LEN  = LEN_W'(LOOP_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(LOOP_DEPTH - 1);

    // encoder step codes, two's complement
    localparam logic [1:0] TURN_NONE  = 2'b00;
    localparam logic [1:0] TURN_UP    = 2'b01;
    localparam logic [1:0] TURN_DOWN2 = 2'b10;
    localparam logic [1:0] TURN_DOWN  = 2'b11;

    typedef struct packed {
        logic [ADDR_W-1:0] pos;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  first_cnt;
        logic              first_pend;
        logic              rec;
        logic [SEL_W-1:0]  sel;
    } loop_state_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [TRK_N-1:0]  mask;
    } store_write_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODIFY,
        ST_FETCH
    } phase_t;

endpackage

[rtl/core/tttl_ram.sv]
// tttl_ram: generic simple dual-port ram, one write and one registered read port
// read during write to the same address returns the old contents
// no dependencies
module tttl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/tttl_tick.sv]
// tttl_tick: next loop state and store write request for one control tick
// press, hold, encoder turn, gate, advance and first-pass count in that order
// depends on tttl_pkg
module tttl_tick (
    input  tttl_pkg::loop_state_t  cur_state,
    input  logic                   press_edge,
    input  logic                   hold_long,
    input  logic signed [1:0]      turn_step,
    input  logic                   gate_hit,
    output tttl_pkg::loop_state_t  next_state,
    output tttl_pkg::store_write_t store_wr,
    output logic                   clear_all
);

    tttl_pkg::loop_state_t      s;
    logic [1:0]                 add;
    logic [tttl_pkg::SEL_W:0]   sel_sum;
    logic [tttl_pkg::LEN_W-1:0] pos_inc;
    logic [tttl_pkg::LEN_W-1:0] cnt_inc;

    always_comb
    begin
        s        = cur_state;
        store_wr = '0;
        add      = 2'd0;
        pos_inc  = '0;
        cnt_inc  = '0;
        sel_sum  = '0;

        if (press_edge)
        begin
            if (s.first_pend && s.rec)
            begin
                s.first_pend = 1'b0;
                s.len        = s.first_cnt;
                s.first_cnt  = '0;
                s.pos        = '0;
            end
            s.rec = !s.rec;
        end

        if (hold_long)
        begin
            s.pos        = '0;
            s.len        = tttl_pkg::LOOP_LEN;
            s.first_cnt  = '0;
            s.first_pend = 1'b1;
            s.rec        = 1'b0;
        end

        case (turn_step)
            tttl_pkg::TURN_NONE:  add = 2'd0;
            tttl_pkg::TURN_UP:    add = 2'd1;
            tttl_pkg::TURN_DOWN2: add = 2'd1;
            tttl_pkg::TURN_DOWN:  add = 2'd2;
            default:              add = 2'd0;
        endcase
        sel_sum = {1'b0, s.sel} + {1'b0, add};
        if (sel_sum >= 3'(tttl_pkg::TRK_N))
        begin
            sel_sum = sel_sum - 3'(tttl_pkg::TRK_N);
        end
        s.sel = sel_sum[tttl_pkg::SEL_W-1:0];

        store_wr.addr = s.pos;
        store_wr.mask = tttl_pkg::TRK_N'(1) << s.sel;
        if (gate_hit && (s.rec || s.first_pend))
        begin
            store_wr.en = 1'b1;
            s.rec       = 1'b1;
        end

        if (!(s.first_pend && !s.rec))
        begin
            pos_inc = {1'b0, s.pos} + tttl_pkg::LEN_W'(1);
            if (pos_inc >= s.len)
            begin
                s.pos = '0;
            end
            else
            begin
                s.pos = pos_inc[tttl_pkg::ADDR_W-1:0];
            end
        end

        if (s.first_pend && s.rec)
        begin
            cnt_inc = s.first_cnt + tttl_pkg::LEN_W'(1);
            if (cnt_inc >= tttl_pkg::LOOP_LEN)
            begin
                s.first_pend = 1'b0;
                s.len        = tttl_pkg::LOOP_LEN;
                s.first_cnt  = '0;
                s.pos        = '0;
            end
            else
            begin
                s.first_cnt = cnt_inc;
            end
        end

        next_state = s;
        clear_all  = hold_long;
    end

endmodule

[rtl/core/three_track_trigger_looper.sv]
// three_track_trigger_looper: top level, sequencer around the loop store
// depends on tttl_pkg, tttl_tick and tttl_ram
//
// usage
// s_* carries one control tick per transaction: press, long hold, encoder
// step and gate hit. m_* returns one status transaction per tick: the three
// track trigger bits at the new play position, recording flag, selected
// track and the waiting-for-first-pass flag.
// an ordinary tick passes through the idle, modify and fetch phases: the
// store is read at the write position, written back with the gate hit
// merged in while the new position is read, then the result goes to the
// output register. a new tick is taken only after the previous one has left
// the fetch phase, as the store ports serve the read-modify-write and read.
// a long hold sweeps the whole store, one entry per cycle (LOOP_DEPTH
// entries, 65536 as built), before the tick completes; s_tready stays low.
// after reset the same sweep runs first, with s_tready low until it ends.
// a stalled m_tready holds the result in the output register, and
// a following tick is still accepted; the sequencer waits only when it has
// a fresh result and the output register is still full.
module three_track_trigger_looper (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tttl_pkg::IN_DATA_W-1:0]    s_tdata,   // press_edge, hold_long,
                                                         // turn_step[1:0], gate_hit, zeros
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tttl_pkg::OUT_DATA_W-1:0]   m_tdata    // track_triggers[2:0], recording,
                                                         // selected_track[1:0],
                                                         // awaiting_first, zero
);

    tttl_pkg::phase_t       fsm_reg, fsm_next;
    tttl_pkg::loop_state_t  loop_reg, loop_next;
    tttl_pkg::store_write_t wr_reg, wr_next;
    logic                   pend_reg, pend_next;
    logic [tttl_pkg::ADDR_W-1:0]     clr_addr_reg, clr_addr_next;
    logic                   fwd_hit_reg, fwd_hit_next;
    logic [tttl_pkg::TRK_N-1:0]      fwd_data_reg, fwd_data_next;
    logic                   out_valid_reg, out_valid_next;
    logic [tttl_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    tttl_pkg::loop_state_t  tick_state;
    tttl_pkg::store_write_t tick_wr;
    logic                   tick_clear;

    logic                            ram_we;
    logic [tttl_pkg::ADDR_W-1:0]     ram_waddr;
    logic [tttl_pkg::TRK_N-1:0]      ram_wdata;
    logic [tttl_pkg::ADDR_W-1:0]     ram_raddr;
    logic [tttl_pkg::TRK_N-1:0]      ram_rdata;
    logic [tttl_pkg::TRK_N-1:0]      trig_bits;
    logic                            out_free;

    tttl_tick u_tick (
        .cur_state  (loop_reg),
        .press_edge (s_tdata[0]),
        .hold_long  (s_tdata[1]),
        .turn_step  (s_tdata[3:2]),
        .gate_hit   (s_tdata[4]),
        .next_state (tick_state),
        .store_wr   (tick_wr),
        .clear_all  (tick_clear)
    );

    tttl_ram #(
        .WIDTH (tttl_pkg::TRK_N),
        .DEPTH (tttl_pkg::LOOP_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || m_tready;
    assign trig_bits = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    always_comb
    begin
        fsm_next       = fsm_reg;
        loop_next      = loop_reg;
        wr_next        = wr_reg;
        pend_next      = pend_reg;
        clr_addr_next  = clr_addr_reg;
        fwd_hit_next   = fwd_hit_reg;
        fwd_data_next  = fwd_data_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = wr_reg.addr;
        ram_wdata      = '0;
        ram_raddr      = loop_reg.pos;
        s_tready       = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (fsm_reg)
            tttl_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
                ram_raddr = wr_reg.addr;
                if (clr_addr_reg == tttl_pkg::LAST_ADDR)
                begin
                    clr_addr_next = '0;
                    pend_next     = 1'b0;
                    fsm_next      = pend_reg ? tttl_pkg::ST_MODIFY : tttl_pkg::ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + tttl_pkg::ADDR_W'(1);
                end
            end
            tttl_pkg::ST_IDLE:
            begin
                s_tready  = 1'b1;
                ram_raddr = tick_wr.addr;
                if (s_tvalid)
                begin
                    loop_next = tick_state;
                    wr_next   = tick_wr;
                    if (tick_clear)
                    begin
                        pend_next     = 1'b1;
                        clr_addr_next = '0;
                        fsm_next      = tttl_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        fsm_next = tttl_pkg::ST_MODIFY;
                    end
                end
            end
            tttl_pkg::ST_MODIFY:
            begin
                ram_we        = wr_reg.en;
                ram_waddr     = wr_reg.addr;
                ram_wdata     = ram_rdata | wr_reg.mask;
                ram_raddr     = loop_reg.pos;
                fwd_hit_next  = wr_reg.en && (wr_reg.addr == loop_reg.pos);
                fwd_data_next = ram_rdata | wr_reg.mask;
                fsm_next      = tttl_pkg::ST_FETCH;
            end
            tttl_pkg::ST_FETCH:
            begin
                ram_raddr = loop_reg.pos;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, loop_reg.first_pend, loop_reg.sel,
                                      loop_reg.rec, trig_bits};
                    fsm_next       = tttl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                fsm_next = tttl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg            <= tttl_pkg::ST_CLEAR;
            loop_reg.pos       <= '0;
            loop_reg.len       <= tttl_pkg::LOOP_LEN;
            loop_reg.first_cnt <= '0;
            loop_reg.first_pend <= 1'b1;
            loop_reg.rec       <= 1'b0;
            loop_reg.sel       <= '0;
            wr_reg             <= '0;
            pend_reg           <= 1'b0;
            clr_addr_reg       <= '0;
            fwd_hit_reg        <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            loop_reg      <= loop_next;
            wr_reg        <= wr_next;
            pend_reg      <= pend_next;
            clr_addr_reg  <= clr_addr_next;
            fwd_hit_reg   <= fwd_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= fwd_data_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // play position always inside the loop
    a_pos_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, loop_reg.pos} < loop_reg.len)
        else $error("play position outside loop length");

    // selected track is one of three
    a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
        loop_reg.sel != 2'd3)
        else $error("selected track out of range");

    // first-pass count is idle once the loop length is set
    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !loop_reg.first_pend |-> (loop_reg.first_cnt == '0))
        else $error("first-pass count running after loop length set");

    // a result appears only out of the fetch phase
    a_out_from_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(fsm_reg) == tttl_pkg::ST_FETCH))
        else $error("result raised outside fetch phase");

    // no transaction taken while the store is busy
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (fsm_reg == tttl_pkg::ST_MODIFY
                                     || fsm_reg == tttl_pkg::ST_CLEAR))
        else $error("transaction accepted outside idle phase");
`endif

endmodule
